// ===== design/igdt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// igdt_pkg
// Shared types and constants for the grouped decimal text formatter.
// ----------------------------------------------------------------------------
package igdt_pkg;

    localparam logic [5:0] ASCII_ZERO  = 6'd48;
    localparam logic [5:0] ASCII_COMMA = 6'd44;

    // input bits consumed per double-dabble step
    localparam int DABBLE_STEP = 4;

    // position of a digit inside its group of three, counted from the right
    localparam logic [1:0] GROUP_TOP = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_FIND,
        ST_DIGIT,
        ST_COMMA
    } state_t;

    typedef struct packed {
        logic load;
        logic shift;
        logic find;
        logic emit_digit;
        logic emit_comma;
    } cmd_t;

    typedef struct packed {
        logic conv_last;
        logic idx_zero;
        logic grp_zero;
        logic out_free;
    } status_t;

endpackage
`default_nettype wire

// ===== design/integer_to_grouped_decimal_text_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// integer_to_grouped_decimal_text_core
// Formats an unsigned integer as ASCII decimal text with a comma between
// groups of three digits, one character per output transaction.
// ----------------------------------------------------------------------------
//  channel  ports                          content
//  s_       s_valid s_ready s_value        integer to format
//  m_       m_valid m_ready m_text_char    one character, msd first
//           m_is_last                      set on the final character
//
//  an item passes through an accept step, double-dabble conversion of
//  DABBLE_STEP input bits per step, a digit search, then character
//  emission (up to 13 characters at 31 bits) in the emission sequencer
//  the next item is accepted once the last character sits in the output
//  register; back pressure on m_ stalls emission without loss
//  reset: aresetn synchronous, active low, clears the sequencer and m_valid
// ----------------------------------------------------------------------------
module integer_to_grouped_decimal_text_core #(
    parameter int VALUE_BITS = 31
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   s_valid,
    output logic                  s_ready,
    input  wire  [VALUE_BITS-1:0] s_value,
    output logic                  m_valid,
    input  wire                   m_ready,
    output logic [5:0]            m_text_char,
    output logic                  m_is_last
);
    import igdt_pkg::*;

    cmd_t    cmd;
    status_t status;

    igdt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    igdt_datapath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_value     (s_value),
        .cmd         (cmd),
        .status      (status),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_text_char (m_text_char),
        .m_is_last   (m_is_last)
    );

endmodule
`default_nettype wire

// ===== design/igdt_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// igdt_ctrl
// Sequencer: accept, binary to bcd conversion, leading digit search, and
// character emission with comma insertion.
// ----------------------------------------------------------------------------
module igdt_ctrl (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              s_valid,
    output logic             s_ready,
    input  igdt_pkg::status_t status,
    output igdt_pkg::cmd_t    cmd
);
    import igdt_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                cmd.shift = 1'b1;
                if (status.conv_last) begin
                    state_next = ST_FIND;
                end
            end
            ST_FIND: begin
                cmd.find   = 1'b1;
                state_next = ST_DIGIT;
            end
            ST_DIGIT: begin
                if (status.out_free) begin
                    cmd.emit_digit = 1'b1;
                    if (status.idx_zero) begin
                        state_next = ST_IDLE;
                    end else if (status.grp_zero) begin
                        state_next = ST_COMMA;
                    end
                end
            end
            ST_COMMA: begin
                if (status.out_free) begin
                    cmd.emit_comma = 1'b1;
                    state_next     = ST_DIGIT;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== design/igdt_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// igdt_datapath
// Double-dabble converter, digit pointer with group position, and the
// output register of the character channel.
// ----------------------------------------------------------------------------
module igdt_datapath #(
    parameter int VALUE_BITS = 31
) (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire  [VALUE_BITS-1:0]  s_value,
    input  igdt_pkg::cmd_t         cmd,
    output igdt_pkg::status_t      status,
    output logic                   m_valid,
    input  wire                    m_ready,
    output logic [5:0]             m_text_char,
    output logic                   m_is_last
);
    import igdt_pkg::*;

    // decimal digits of the largest value: floor(bits * log10(2)) + 1
    localparam int ND     = (VALUE_BITS * 1233) / 4096 + 1;
    localparam int NSTEPS = (VALUE_BITS + DABBLE_STEP - 1) / DABBLE_STEP;
    localparam int PADW   = NSTEPS * DABBLE_STEP;
    localparam int BCDW   = ND * 4;
    localparam int IDXW   = $clog2(ND);
    localparam int CNTW   = $clog2(NSTEPS + 1);

    logic [PADW-1:0] bin_reg;
    logic [PADW-1:0] bin_next;
    logic [BCDW-1:0] bcd_reg;
    logic [BCDW-1:0] bcd_next;
    logic [CNTW-1:0] cnt_reg;
    logic [IDXW-1:0] idx_reg;
    logic [IDXW-1:0] msd_next;
    logic [1:0]      grp_reg;
    logic [1:0]      grp_next;
    logic            m_valid_reg;
    logic [5:0]      char_reg;
    logic            last_reg;
    logic [3:0]      cur_digit;

    // several add-3 and shift passes per cycle
    always_comb begin
        bcd_next = bcd_reg;
        bin_next = bin_reg;
        for (int k = 0; k < DABBLE_STEP; k++) begin
            for (int d = 0; d < ND; d++) begin
                if (bcd_next[d*4 +: 4] >= 4'd5) begin
                    bcd_next[d*4 +: 4] = bcd_next[d*4 +: 4] + 4'd3;
                end
            end
            {bcd_next, bin_next} = {bcd_next, bin_next} << 1;
        end
    end

    // highest nonzero digit and its place within the group of three
    always_comb begin
        logic [1:0] g;
        msd_next = '0;
        grp_next = 2'd0;
        g        = 2'd0;
        for (int i = 0; i < ND; i++) begin
            if (bcd_reg[i*4 +: 4] != 4'd0) begin
                msd_next = IDXW'(i);
                grp_next = g;
            end
            g = (g == GROUP_TOP) ? 2'd0 : g + 2'd1;
        end
    end

    assign cur_digit = bcd_reg[idx_reg*4 +: 4];

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            bin_reg <= PADW'(s_value);
            bcd_reg <= '0;
            cnt_reg <= CNTW'(NSTEPS);
        end else if (cmd.shift) begin
            bin_reg <= bin_next;
            bcd_reg <= bcd_next;
            cnt_reg <= cnt_reg - CNTW'(1);
        end
        if (cmd.find) begin
            idx_reg <= msd_next;
            grp_reg <= grp_next;
        end else if (cmd.emit_digit) begin
            if (idx_reg != '0 && grp_reg != 2'd0) begin
                idx_reg <= idx_reg - IDXW'(1);
                grp_reg <= grp_reg - 2'd1;
            end
        end else if (cmd.emit_comma) begin
            idx_reg <= idx_reg - IDXW'(1);
            grp_reg <= GROUP_TOP;
        end
        if (cmd.emit_digit) begin
            char_reg <= ASCII_ZERO + {2'b00, cur_digit};
            last_reg <= (idx_reg == '0);
        end else if (cmd.emit_comma) begin
            char_reg <= ASCII_COMMA;
            last_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit_digit || cmd.emit_comma) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign status.conv_last = (cnt_reg == CNTW'(1));
    assign status.idx_zero  = (idx_reg == '0);
    assign status.grp_zero  = (grp_reg == 2'd0);
    assign status.out_free  = !m_valid_reg || m_ready;

    assign m_valid     = m_valid_reg;
    assign m_text_char = char_reg;
    assign m_is_last   = last_reg;

`ifndef NO_ASSERTIONS
    a_shift_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.shift |-> cnt_reg != '0)
        else $error("conversion step issued with no bits left");

    a_emit_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit_digit || cmd.emit_comma) |-> status.out_free)
        else $error("character loaded over an untaken one");

    a_comma_not_first: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit_comma |-> idx_reg != '0 && grp_reg == 2'd0)
        else $error("comma emitted outside a group boundary");

    a_comma_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(cmd.emit_comma) |-> !m_is_last && m_text_char == ASCII_COMMA)
        else $error("comma transaction marked last or corrupted");

    a_digit_group: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit_digit |-> grp_reg != 2'd3)
        else $error("group position out of range");
`endif

endmodule
`default_nettype wire
